// ----- rtl/core/range_min_gcd_segment_tree_macros.svh -----
// Assertion helpers used by range_min_gcd_segment_tree.sv.
`ifndef RANGE_MIN_GCD_SEGMENT_TREE_MACROS_SVH
`define RANGE_MIN_GCD_SEGMENT_TREE_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define RMGST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define RMGST_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- rtl/core/rmgst_pkg.sv -----
package rmgst_pkg;

    // Fixed field widths of the ports.
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 31;
    localparam int ANSWER_W = 32;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_MIN   = 2'd1,
        OP_GCD   = 2'd2,
        OP_COUNT = 2'd3
    } op_t;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_RANGE_ERR = 1'b1;

    // Sequencer states.
    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_QSTEP  = 11'b000_0000_0100,
        ST_QRIGHT = 11'b000_0000_1000,
        ST_QSHIFT = 11'b000_0001_0000,
        ST_PLEFT  = 11'b000_0010_0000,
        ST_PRIGHT = 11'b000_0100_0000,
        ST_PWRITE = 11'b000_1000_0000,
        ST_FOLD   = 11'b001_0000_0000,
        ST_GCD    = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

endpackage

// ----- rtl/core/rmgst_ram.sv -----
module rmgst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/range_min_gcd_segment_tree.sv -----
// Channel | Direction | Handshake          | Beat fields
// in      | input     | in_valid, in_stall | operation, index, value, range_lo, range_hi
// out     | output    | out_valid, out_stall | answer, status
//
// A set walks from the leaf to the root; each level reads two children and
// writes the parent, with one binary gcd run per child.
// A query folds at most 2*log2(LEAVES) nodes, each one read plus one gcd run.
// The single node memory and the shared gcd unit set the cycle count.
// After reset a clearing pass over all 2*LEAVES nodes stalls the input.
// A result waits in the output register; the next beat is taken meanwhile.
`include "range_min_gcd_segment_tree_macros.svh"

module range_min_gcd_segment_tree
    import rmgst_pkg::*;
#(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [INDEX_W-1:0]  index,
    input  logic [VALUE_W-1:0]  value,
    input  logic [INDEX_W-1:0]  range_lo,
    input  logic [INDEX_W-1:0]  range_hi,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ANSWER_W-1:0] answer,
    output logic                status
);

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int PW    = AW + 1;
    localparam int CW    = $clog2(LEAVES) + 1;
    localparam int MW    = VALUE_BITS + 1;
    localparam int SW    = $clog2(VALUE_BITS + 1);
    localparam int EW    = MW + VALUE_BITS + CW;

    state_t                state_reg, state_next;
    state_t                ret_reg, ret_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]         p_reg, p_next;
    logic [PW-1:0]         l_reg, l_next;
    logic [PW-1:0]         r_reg, r_next;
    op_t                   op_reg, op_next;
    logic                  err_reg, err_next;
    logic [MW-1:0]         accm_reg, accm_next;
    logic [VALUE_BITS-1:0] accd_reg, accd_next;
    logic [CW-1:0]         accc_reg, accc_next;
    logic [VALUE_BITS-1:0] ga_reg, ga_next;
    logic [VALUE_BITS-1:0] gb_reg, gb_next;
    logic [SW-1:0]         gk_reg, gk_next;
    logic                  ovalid_reg, ovalid_next;
    logic [ANSWER_W-1:0]   answer_reg, answer_next;
    logic                  status_reg, status_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [EW-1:0]         mem_rdata;

    logic [63:0]           value_wide;
    logic [VALUE_BITS-1:0] val_in;
    logic [31:0]           lo_sat, hi_sat, leaf_idx;
    logic [PW-1:0]         r_dec;
    logic [MW-1:0]         node_m, fold_m;
    logic [VALUE_BITS-1:0] node_d;
    logic [CW-1:0]         node_c, fold_c;
    logic [63:0]           min_wide, div_wide;
    logic [ANSWER_W-1:0]   result;

    // Node memory: minimum, gcd and minimum count packed in one entry.
    rmgst_ram #(
        .WIDTH(EW),
        .DEPTH(NODES)
    ) u_node_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Input decode and bound saturation.
    assign value_wide = 64'(value);
    assign val_in     = value_wide[VALUE_BITS-1:0];
    assign leaf_idx   = 32'(index) + 32'(LEAVES);
    assign lo_sat     = (32'(range_lo) > 32'(LEAVES - 1)) ? 32'(LEAVES - 1) : 32'(range_lo);
    assign hi_sat     = (32'(range_hi) > 32'(LEAVES - 1)) ? 32'(LEAVES - 1) : 32'(range_hi);
    assign r_dec      = r_reg - PW'(1);

    // Fold of one node into the accumulator.
    assign node_m = mem_rdata[EW-1 -: MW];
    assign node_d = mem_rdata[CW +: VALUE_BITS];
    assign node_c = mem_rdata[CW-1:0];
    assign fold_m = (node_m < accm_reg) ? node_m : accm_reg;
    assign fold_c = ((accm_reg == fold_m) ? accc_reg : CW'(0))
                  + ((node_m == fold_m) ? node_c : CW'(0));

    // Query answer by kind.
    assign min_wide = 64'(accm_reg);
    assign div_wide = 64'(accd_reg);
    always_comb
    begin
        unique case (op_reg)
            OP_MIN:
            begin
                result = accm_reg[MW-1] ? '1 : min_wide[ANSWER_W-1:0];
            end
            OP_GCD:
            begin
                result = div_wide[ANSWER_W-1:0];
            end
            OP_COUNT:
            begin
                result = (accm_reg == {1'b0, accd_reg}) ? ANSWER_W'(accc_reg) : '0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        clr_next    = clr_reg;
        p_next      = p_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        op_next     = op_reg;
        err_next    = err_reg;
        accm_next   = accm_reg;
        accd_next   = accd_reg;
        accc_next   = accc_reg;
        ga_next     = ga_reg;
        gb_next     = gb_reg;
        gk_next     = gk_reg;
        ovalid_next = ovalid_reg && out_stall;
        answer_next = answer_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = clr_reg;
        mem_wdata   = {{MW{1'b1}}, {VALUE_BITS{1'b0}}, {CW{1'b0}}};
        mem_raddr   = l_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                accm_next = '1;
                accd_next = '0;
                accc_next = '0;
                if (in_valid)
                begin
                    op_next  = op_t'(operation);
                    err_next = 1'b0;
                    if (op_t'(operation) == OP_SET)
                    begin
                        if (32'(index) < 32'(LEAVES))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = leaf_idx[AW-1:0];
                            mem_wdata  = {1'b0, val_in, val_in, CW'(1)};
                            p_next     = leaf_idx[AW:1];
                            state_next = ST_PLEFT;
                        end
                    end
                    else if (range_lo > range_hi)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        l_next     = PW'(lo_sat + 32'(LEAVES));
                        r_next     = PW'(hi_sat + 32'(LEAVES) + 32'd1);
                        state_next = ST_QSTEP;
                    end
                end
            end
            ST_QSTEP:
            begin
                if (l_reg < r_reg)
                begin
                    if (l_reg[0])
                    begin
                        mem_raddr  = l_reg[AW-1:0];
                        l_next     = l_reg + PW'(1);
                        ret_next   = ST_QRIGHT;
                        state_next = ST_FOLD;
                    end
                    else
                    begin
                        state_next = ST_QRIGHT;
                    end
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_QRIGHT:
            begin
                if (r_reg[0])
                begin
                    mem_raddr  = r_dec[AW-1:0];
                    r_next     = r_dec;
                    ret_next   = ST_QSHIFT;
                    state_next = ST_FOLD;
                end
                else
                begin
                    state_next = ST_QSHIFT;
                end
            end
            ST_QSHIFT:
            begin
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = ST_QSTEP;
            end
            ST_PLEFT:
            begin
                mem_raddr  = {p_reg[AW-2:0], 1'b0};
                ret_next   = ST_PRIGHT;
                state_next = ST_FOLD;
            end
            ST_PRIGHT:
            begin
                mem_raddr  = {p_reg[AW-2:0], 1'b1};
                ret_next   = ST_PWRITE;
                state_next = ST_FOLD;
            end
            ST_PWRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg;
                mem_wdata = {accm_reg, accd_reg, accc_reg};
                accm_next = '1;
                accd_next = '0;
                accc_next = '0;
                if (p_reg == AW'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    p_next     = p_reg >> 1;
                    state_next = ST_PLEFT;
                end
            end
            ST_FOLD:
            begin
                accm_next  = fold_m;
                accc_next  = fold_c;
                ga_next    = accd_reg;
                gb_next    = node_d;
                gk_next    = '0;
                state_next = ST_GCD;
            end
            ST_GCD:
            begin
                // One binary gcd step per cycle.
                priority if (ga_reg == '0)
                begin
                    accd_next  = gb_reg << gk_reg;
                    state_next = ret_reg;
                end
                else if (gb_reg == '0)
                begin
                    accd_next  = ga_reg << gk_reg;
                    state_next = ret_reg;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + SW'(1);
                end
                else if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (ga_reg >= gb_reg)
                begin
                    ga_next = (ga_reg - gb_reg) >> 1;
                end
                else
                begin
                    gb_next = (gb_reg - ga_reg) >> 1;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    answer_next = err_reg ? '0 : result;
                    status_next = err_reg ? STATUS_RANGE_ERR : STATUS_OK;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ret_reg    <= ST_IDLE;
            clr_reg    <= '0;
            p_reg      <= '0;
            l_reg      <= '0;
            r_reg      <= '0;
            op_reg     <= OP_SET;
            err_reg    <= 1'b0;
            accm_reg   <= '1;
            accd_reg   <= '0;
            accc_reg   <= '0;
            ga_reg     <= '0;
            gb_reg     <= '0;
            gk_reg     <= '0;
            ovalid_reg <= 1'b0;
            answer_reg <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            clr_reg    <= clr_next;
            p_reg      <= p_next;
            l_reg      <= l_next;
            r_reg      <= r_next;
            op_reg     <= op_next;
            err_reg    <= err_next;
            accm_reg   <= accm_next;
            accd_reg   <= accd_next;
            accc_reg   <= accc_next;
            ga_reg     <= ga_next;
            gb_reg     <= gb_next;
            gk_reg     <= gk_next;
            ovalid_reg <= ovalid_next;
            answer_reg <= answer_next;
            status_reg <= status_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

    // Checks on the sequencer.
    `RMGST_ASSERT(a_err_answer_zero, !(out_valid && status == STATUS_RANGE_ERR) || answer == '0, "range error beat carries a nonzero answer")
    `RMGST_ASSERT(a_rose_from_out, !$rose(ovalid_reg) || $past(state_reg == ST_OUT), "result appeared outside the output state")
    `RMGST_ASSERT(a_query_window, state_reg != ST_QRIGHT || l_reg <= r_reg, "query window bounds crossed")
    `RMGST_ASSERT_NEXT(a_fold_to_gcd, state_reg == ST_FOLD, state_reg == ST_GCD, "fold not followed by gcd")

endmodule
